// ===== hdl/wpc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types, constants and trig tables for the wall projection pipeline.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int FOCAL_LENGTH       = 200;
  localparam int SCREEN_WIDTH       = 640;
  localparam int SCREEN_HEIGHT      = 480;
  localparam int WALL_HEIGHT        = 80;
  localparam int TRIG_FRACTION_BITS = 14;

  localparam int CENTRE_X = SCREEN_WIDTH / 2;
  localparam int CENTRE_Y = SCREEN_HEIGHT / 2;

  localparam int TRIG_W  = TRIG_FRACTION_BITS + 2;   // signed Q2.F
  localparam int TRIG_N  = 360;
  localparam int HEAD_W  = 9;
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int ROT_W   = 20;                       // rotated x / depth
  localparam int Z_W     = 24;                       // vertical offsets
  localparam int CD_W    = ROT_W + 1;                // clip differences

  // signed divider: truncating, one quotient bit per stage
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = CD_W;
  localparam int DIV_Q     = 36;
  localparam int DIV_LAT   = DIV_Q + 2;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING  = 3'd4;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [TRIG_N];

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic        [7:0]         colour;
    logic                      wv;
  } wall_in_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [Z_W-1:0]   z;
    logic signed [Z_W-1:0]   c;
  } ep_t;

  typedef struct packed {
    logic       v;
    logic       vis;
    logic       clip0;
    logic       clip1;
    logic [7:0] colour;
    ep_t        ep0;
    ep_t        ep1;
  } side_t;

  typedef struct packed {
    logic              visible;
    logic signed [15:0] lx;
    logic signed [15:0] rx;
    logic signed [15:0] lb;
    logic signed [15:0] rb;
    logic signed [15:0] lc;
    logic signed [15:0] rc;
    logic [7:0]         colour;
  } res_t;

  function automatic trig_tab_t build_sin();
    trig_tab_t   tab;
    logic [63:0] quarter [91];
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int d = 0; d <= 90; d++) begin
      x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      quarter[d] = (64'(sum) + (64'd1 << (29 - TRIG_FRACTION_BITS)))
                   >> (30 - TRIG_FRACTION_BITS);
    end
    for (int d = 0; d < TRIG_N; d++) begin
      if (d <= 90) tab[d] = TRIG_W'(quarter[d]);
      else if (d <= 180) tab[d] = TRIG_W'(quarter[180 - d]);
      else if (d <= 270) tab[d] = -TRIG_W'(quarter[d - 180]);
      else tab[d] = -TRIG_W'(quarter[360 - d]);
    end
    return tab;
  endfunction

  function automatic trig_tab_t build_cos();
    trig_tab_t s;
    trig_tab_t c;
    s = build_sin();
    for (int d = 0; d < TRIG_N; d++) begin
      if (d + 90 >= TRIG_N) c[d] = s[d - 270];
      else c[d] = s[d + 90];
    end
    return c;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin();
  localparam trig_tab_t COS_TAB = build_cos();

endpackage

// ===== hdl/wpc_div.sv =====
// ----------------------------------------------------------------------------
// wpc_div
// Pipelined signed divider, truncates toward zero, one quotient bit a stage.
// ----------------------------------------------------------------------------
module wpc_div import wpc_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [DIV_NUM_W-1:0] num,
  input  logic signed [DIV_DEN_W-1:0] den,
  output logic signed [DIV_Q:0]       quo
);

  localparam int REM_W = DIV_DEN_W;
  localparam int TOP_W = DIV_NUM_W - DIV_Q;

  logic [DIV_NUM_W-1:0] num_mag;
  logic [DIV_DEN_W-1:0] den_mag;
  logic [REM_W-1:0]     rem [DIV_Q+1];
  logic [DIV_Q-1:0]     low [DIV_Q+1];
  logic [DIV_DEN_W-1:0] dv  [DIV_Q+1];
  logic                 neg [DIV_Q+1];
  logic signed [DIV_Q:0] qs;

  assign num_mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
  assign den_mag = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {{(REM_W-TOP_W){1'b0}}, num_mag[DIV_NUM_W-1:DIV_Q]};
      low[0] <= num_mag[DIV_Q-1:0];
      dv[0]  <= den_mag;
      neg[0] <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
    end
  end

  for (genvar i = 0; i < DIV_Q; i++) begin : g_step
    logic [REM_W:0] shifted;
    logic [REM_W:0] trial;
    logic           ge;
    assign shifted = {rem[i], low[i][DIV_Q-1]};
    assign trial   = shifted - {1'b0, dv[i]};
    assign ge      = shifted >= {1'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? trial[REM_W-1:0] : shifted[REM_W-1:0];
        low[i+1] <= {low[i][DIV_Q-2:0], ge};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  assign qs = signed'({1'b0, low[DIV_Q]});

  always_ff @(posedge clk) begin
    if (en) quo <= neg[DIV_Q] ? -qs : qs;
  end

endmodule

// ===== hdl/wpc_delay.sv =====
// ----------------------------------------------------------------------------
// wpc_delay
// Side-band delay line matching the divider latency.
// ----------------------------------------------------------------------------
module wpc_delay import wpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  side_t d_in,
  output side_t d_out
);

  side_t line [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= d_in;
      for (int i = 1; i < DIV_LAT; i++) line[i] <= line[i-1];
    end
  end

  assign d_out = line[DIV_LAT-1];

endmodule

// ===== hdl/wpc_front.sv =====
// ----------------------------------------------------------------------------
// wpc_front
// Translate, rotate and height stages; flags for visibility and clipping.
// ----------------------------------------------------------------------------
module wpc_front import wpc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic signed [COORD_W-1:0]  viewer_x,
  input  logic signed [COORD_W-1:0]  viewer_y,
  input  logic signed [COORD_W-1:0]  viewer_z,
  input  logic signed [7:0]          pitch,
  input  logic signed [TRIG_W-1:0]   cs,
  input  logic signed [TRIG_W-1:0]   sn,
  input  logic                       in_v,
  input  wall_in_t                   wall,
  output side_t                      side
);

  localparam int PROD_W = DIFF_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int T_W    = ROT_W + 9;

  typedef struct packed {
    logic       v;
    logic       wv;
    logic [7:0] colour;
  } meta_t;

  meta_t ma, mb, mc, md;

  logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2;
  logic signed [PROD_W-1:0] xc1, ys1, yc1, xs1, xc2, ys2, yc2, xs2;
  logic signed [SUM_W-1:0]  sx0, sy0, sx1, sy1;
  logic signed [ROT_W-1:0]  wx0, wy0, wx1, wy1;
  logic signed [ROT_W-1:0]  dwx0, dwy0, dwx1, dwy1;
  logic signed [T_W-1:0]    t0, t1;
  logic signed [Z_W-1:0]    z0, z1;
  logic                     behind0, behind1;

  function automatic logic signed [ROT_W-1:0] rot_trunc(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] b;
    b = v[SUM_W-1] ? v + SUM_W'((1 << TRIG_FRACTION_BITS) - 1) : v;
    return ROT_W'(b >>> TRIG_FRACTION_BITS);
  endfunction

  function automatic logic signed [Z_W-1:0] z_trunc(input logic signed [T_W-1:0] v);
    logic signed [T_W-1:0] b;
    b = v[T_W-1] ? v + T_W'(31) : v;
    return Z_W'(b >>> 5);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ma <= '0;
      mb <= '0;
      mc <= '0;
      md <= '0;
      side.v <= 1'b0;
    end else if (en) begin
      ma <= '{v: in_v, wv: wall.wv, colour: wall.colour};
      mb <= ma;
      mc <= mb;
      md <= mc;
      side.v <= md.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // relative to viewer
      dx1 <= DIFF_W'(wall.x1) - DIFF_W'(viewer_x);
      dy1 <= DIFF_W'(wall.y1) - DIFF_W'(viewer_y);
      dx2 <= DIFF_W'(wall.x2) - DIFF_W'(viewer_x);
      dy2 <= DIFF_W'(wall.y2) - DIFF_W'(viewer_y);
      // rotation products
      xc1 <= PROD_W'(dx1) * PROD_W'(cs);
      ys1 <= PROD_W'(dy1) * PROD_W'(sn);
      yc1 <= PROD_W'(dy1) * PROD_W'(cs);
      xs1 <= PROD_W'(dx1) * PROD_W'(sn);
      xc2 <= PROD_W'(dx2) * PROD_W'(cs);
      ys2 <= PROD_W'(dy2) * PROD_W'(sn);
      yc2 <= PROD_W'(dy2) * PROD_W'(cs);
      xs2 <= PROD_W'(dx2) * PROD_W'(sn);
      wx0 <= rot_trunc(sx0);
      wy0 <= rot_trunc(sy0);
      wx1 <= rot_trunc(sx1);
      wy1 <= rot_trunc(sy1);
      // pitch offset
      t0   <= T_W'(pitch) * T_W'(wy0) - (T_W'(viewer_z) <<< 5);
      t1   <= T_W'(pitch) * T_W'(wy1) - (T_W'(viewer_z) <<< 5);
      dwx0 <= wx0;
      dwy0 <= wy0;
      dwx1 <= wx1;
      dwy1 <= wy1;
      side.vis    <= md.wv & ~(behind0 & behind1);
      side.clip0  <= behind0;
      side.clip1  <= behind1;
      side.colour <= md.colour;
      side.ep0    <= '{x: dwx0, y: dwy0, z: z0, c: z0 + Z_W'(WALL_HEIGHT)};
      side.ep1    <= '{x: dwx1, y: dwy1, z: z1, c: z1 + Z_W'(WALL_HEIGHT)};
    end
  end

  assign sx0 = SUM_W'(xc1) - SUM_W'(ys1);
  assign sy0 = SUM_W'(yc1) + SUM_W'(xs1);
  assign sx1 = SUM_W'(xc2) - SUM_W'(ys2);
  assign sy1 = SUM_W'(yc2) + SUM_W'(xs2);
  assign z0  = z_trunc(t0);
  assign z1  = z_trunc(t1);
  // depth below one
  assign behind0 = dwy0[ROT_W-1] | (dwy0 == '0);
  assign behind1 = dwy1[ROT_W-1] | (dwy1 == '0);

endmodule

// ===== hdl/wpc_clip.sv =====
// ----------------------------------------------------------------------------
// wpc_clip
// Near-plane clip: moves the endpoint behind the viewer along the segment.
// ----------------------------------------------------------------------------
module wpc_clip import wpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  side_t side_in,
  output side_t side_out
);

  localparam int DZ_W = Z_W + 1;
  localparam int PX_W = ROT_W + CD_W;
  localparam int PZ_W = Z_W + CD_W;
  localparam int PD_W = ROT_W + DZ_W;

  side_t sf, sg, sd;
  ep_t   a, b;

  logic signed [CD_W-1:0] den_c, den_f, den_g;
  logic signed [CD_W-1:0] dx_f;
  logic signed [DZ_W-1:0] dz_f;
  logic signed [ROT_W-1:0] xa_f, da_f;
  logic signed [Z_W-1:0]   za_f;
  logic signed [PX_W-1:0]  p_xd, p_dx;
  logic signed [PZ_W-1:0]  p_zd;
  logic signed [PD_W-1:0]  p_dz;
  logic signed [DIV_NUM_W-1:0] nx, nz, nc;
  logic signed [DIV_Q:0]   qx, qz, qc;
  ep_t                     ep_clip;

  assign a     = side_in.clip0 ? side_in.ep0 : side_in.ep1;
  assign b     = side_in.clip0 ? side_in.ep1 : side_in.ep0;
  assign den_c = CD_W'(a.y) - CD_W'(b.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      sf.v <= 1'b0;
      sg.v <= 1'b0;
      side_out.v <= 1'b0;
    end else if (en) begin
      sf.v <= side_in.v;
      sg.v <= sf.v;
      side_out.v <= sd.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf[$bits(side_t)-2:0] <= side_in[$bits(side_t)-2:0];
      den_f <= (den_c == '0) ? CD_W'(1) : den_c;
      dx_f  <= CD_W'(b.x) - CD_W'(a.x);
      dz_f  <= DZ_W'(b.z) - DZ_W'(a.z);
      xa_f  <= a.x;
      za_f  <= a.z;
      da_f  <= a.y;
      sg[$bits(side_t)-2:0] <= sf[$bits(side_t)-2:0];
      den_g <= den_f;
      p_xd  <= PX_W'(xa_f) * PX_W'(den_f);
      p_dx  <= PX_W'(da_f) * PX_W'(dx_f);
      p_zd  <= PZ_W'(za_f) * PZ_W'(den_f);
      p_dz  <= PD_W'(da_f) * PD_W'(dz_f);
    end
  end

  assign nx = DIV_NUM_W'(p_xd) + DIV_NUM_W'(p_dx);
  assign nz = DIV_NUM_W'(p_zd) + DIV_NUM_W'(p_dz);
  // raised edge: both ends shift by the wall height
  assign nc = nz + DIV_NUM_W'(den_g) * DIV_NUM_W'(WALL_HEIGHT);

  wpc_div u_div_x (.clk(clk), .en(en), .num(nx), .den(den_g), .quo(qx));
  wpc_div u_div_z (.clk(clk), .en(en), .num(nz), .den(den_g), .quo(qz));
  wpc_div u_div_c (.clk(clk), .en(en), .num(nc), .den(den_g), .quo(qc));

  wpc_delay u_dly (.clk(clk), .rst(rst), .en(en), .d_in(sg), .d_out(sd));

  // clipped depth is always exactly the near plane
  assign ep_clip = '{x: qx[ROT_W-1:0], y: ROT_W'(1), z: qz[Z_W-1:0], c: qc[Z_W-1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.vis    <= sd.vis;
      side_out.clip0  <= sd.clip0;
      side_out.clip1  <= sd.clip1;
      side_out.colour <= sd.colour;
      side_out.ep0    <= (sd.vis && sd.clip0) ? ep_clip : sd.ep0;
      side_out.ep1    <= (sd.vis && !sd.clip0 && sd.clip1) ? ep_clip : sd.ep1;
    end
  end

endmodule

// ===== hdl/wpc_project.sv =====
// ----------------------------------------------------------------------------
// wpc_project
// Perspective divide by depth, screen centring and 16-bit saturation.
// ----------------------------------------------------------------------------
module wpc_project import wpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  side_t side_in,
  output logic  res_v,
  output res_t  res
);

  localparam int FL_W = $clog2(FOCAL_LENGTH + 1) + 1;
  localparam int MX_W = ROT_W + FL_W;
  localparam int MZ_W = Z_W + FL_W;
  localparam int S_W  = DIV_Q + 2;

  side_t sj, sd;
  logic signed [MX_W-1:0] mx0, mx1;
  logic signed [MZ_W-1:0] mz0, mz1, mc0, mc1;
  logic signed [DIV_DEN_W-1:0] d0, d1;
  logic signed [DIV_Q:0] qx0, qx1, qz0, qz1, qc0, qc1;

  function automatic logic signed [15:0] place(input logic signed [DIV_Q:0] q,
                                               input int centre);
    logic signed [S_W-1:0] s;
    s = S_W'(q) + S_W'(centre);
    if (s > S_W'(32767)) return 16'sh7fff;
    if (s < -S_W'(32768)) return 16'sh8000;
    return s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sj.v  <= 1'b0;
      res_v <= 1'b0;
    end else if (en) begin
      sj.v  <= side_in.v;
      res_v <= sd.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sj[$bits(side_t)-2:0] <= side_in[$bits(side_t)-2:0];
      mx0 <= MX_W'(side_in.ep0.x) * MX_W'(FOCAL_LENGTH);
      mx1 <= MX_W'(side_in.ep1.x) * MX_W'(FOCAL_LENGTH);
      mz0 <= MZ_W'(side_in.ep0.z) * MZ_W'(FOCAL_LENGTH);
      mz1 <= MZ_W'(side_in.ep1.z) * MZ_W'(FOCAL_LENGTH);
      mc0 <= MZ_W'(side_in.ep0.c) * MZ_W'(FOCAL_LENGTH);
      mc1 <= MZ_W'(side_in.ep1.c) * MZ_W'(FOCAL_LENGTH);
    end
  end

  assign d0 = DIV_DEN_W'(sj.ep0.y);
  assign d1 = DIV_DEN_W'(sj.ep1.y);

  wpc_div u_div_x0 (.clk(clk), .en(en), .num(DIV_NUM_W'(mx0)), .den(d0), .quo(qx0));
  wpc_div u_div_x1 (.clk(clk), .en(en), .num(DIV_NUM_W'(mx1)), .den(d1), .quo(qx1));
  wpc_div u_div_z0 (.clk(clk), .en(en), .num(DIV_NUM_W'(mz0)), .den(d0), .quo(qz0));
  wpc_div u_div_z1 (.clk(clk), .en(en), .num(DIV_NUM_W'(mz1)), .den(d1), .quo(qz1));
  wpc_div u_div_c0 (.clk(clk), .en(en), .num(DIV_NUM_W'(mc0)), .den(d0), .quo(qc0));
  wpc_div u_div_c1 (.clk(clk), .en(en), .num(DIV_NUM_W'(mc1)), .den(d1), .quo(qc1));

  wpc_delay u_dly (.clk(clk), .rst(rst), .en(en), .d_in(sj), .d_out(sd));

  always_ff @(posedge clk) begin
    if (en) begin
      res.visible <= sd.vis;
      res.colour  <= sd.colour;
      res.lx <= sd.vis ? place(qx0, CENTRE_X) : '0;
      res.rx <= sd.vis ? place(qx1, CENTRE_X) : '0;
      res.lb <= sd.vis ? place(qz0, CENTRE_Y) : '0;
      res.rb <= sd.vis ? place(qz1, CENTRE_Y) : '0;
      res.lc <= sd.vis ? place(qc0, CENTRE_Y) : '0;
      res.rc <= sd.vis ? place(qc1, CENTRE_Y) : '0;
    end
  end

endmodule

// ===== hdl/wall_projection_near_clip.sv =====
// ----------------------------------------------------------------------------
// wall_projection_near_clip
// Projects one wall segment to a screen trapezoid with near-plane clipping.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+-------------------------------------
//   s_axis   | in  | tvalid / tready    | wall endpoints, colour; tuser=valid
//   m_axis   | out | tvalid / tready    | screen x/y per edge, colour; tuser=vis
//   cfg      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One word per cycle sustained while the skid word is free; m_axis_tvalid rises
// after the input, front, clip, projection and output registers.
// Most of the pipeline depth lies in the two 36-stage dividers in series (clip,
// then perspective divide), one quotient bit per stage.
// Reset (rst, synchronous) clears the valid bits, the output and skid valid
// flags among them, and the viewer registers. A stall on m_axis freezes the
// whole pipeline once the skid word fills; until then, words are still taken.
// Viewer registers feed the pipeline directly; write them while idle.
//
module wall_projection_near_clip import wpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // s_axis tdata: wall_x1[15:0] wall_y1[31:16] wall_x2[47:32] wall_y2[63:48]
  //               wall_colour[71:64]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,
  input  logic         s_axis_tuser,   // wall_valid
  // m_axis tdata: left_x[15:0] right_x[31:16] left_base[47:32]
  //               right_base[63:48] left_cap[79:64] right_cap[95:80]
  //               colour_out[103:96]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tuser,   // visible
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]  cfg_data
);

  logic signed [COORD_W-1:0] viewer_x, viewer_y, viewer_z;
  logic signed [7:0]         pitch;
  logic [HEAD_W-1:0]         heading;
  logic [HEAD_W-1:0]         head_idx;
  logic signed [TRIG_W-1:0]  cs, sn;

  logic      en;
  logic      in_v;
  wall_in_t  wall;
  side_t     s_front, s_clip;
  logic      res_v;
  res_t      res;

  logic      out_v, skid_v;
  res_t      out_w, skid_w;

  assign cfg_ready = 1'b1;

  // viewer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      viewer_x <= '0;
      viewer_y <= '0;
      viewer_z <= '0;
      pitch    <= '0;
      heading  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VIEWER_X: viewer_x <= cfg_data;
        CFG_VIEWER_Y: viewer_y <= cfg_data;
        CFG_VIEWER_Z: viewer_z <= cfg_data;
        CFG_PITCH:    pitch    <= cfg_data[7:0];
        CFG_HEADING:  heading  <= cfg_data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // headings past a full turn wrap once
  assign head_idx = (heading >= HEAD_W'(TRIG_N)) ? heading - HEAD_W'(TRIG_N) : heading;

  // trig ROM, registered read
  always_ff @(posedge clk) begin
    cs <= COS_TAB[head_idx];
    sn <= SIN_TAB[head_idx];
  end

  // pipeline advances whenever the skid word is free
  assign en            = ~skid_v;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wall.x1     <= s_axis_tdata[15:0];
      wall.y1     <= s_axis_tdata[31:16];
      wall.x2     <= s_axis_tdata[47:32];
      wall.y2     <= s_axis_tdata[63:48];
      wall.colour <= s_axis_tdata[71:64];
      wall.wv     <= s_axis_tuser;
    end
  end

  wpc_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .viewer_x(viewer_x), .viewer_y(viewer_y), .viewer_z(viewer_z),
    .pitch(pitch), .cs(cs), .sn(sn),
    .in_v(in_v), .wall(wall), .side(s_front)
  );

  wpc_clip u_clip (
    .clk(clk), .rst(rst), .en(en), .side_in(s_front), .side_out(s_clip)
  );

  wpc_project u_project (
    .clk(clk), .rst(rst), .en(en), .side_in(s_clip), .res_v(res_v), .res(res)
  );

  // output register plus one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !m_axis_tready) begin
      if (!skid_v && res_v) begin
        skid_w <= res;
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_w  <= skid_w;
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_w <= res;
      out_v <= res_v;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = out_w.visible;
  assign m_axis_tdata  = {out_w.colour, out_w.rc, out_w.lc, out_w.rb, out_w.lb,
                          out_w.rx, out_w.lx};

endmodule

// ===== hdl/wpc_checker.sv =====
// ----------------------------------------------------------------------------
// wpc_checker
// Port-level checks for the wall projection block.
// ----------------------------------------------------------------------------
module wpc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // a pending word is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // hidden walls carry zero geometry
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:0] == 96'd0)
    else $error("hidden wall with nonzero geometry");

  // input only backs up when an output word is waiting
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output pending");

  // nothing shows right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind wall_projection_near_clip wpc_checker u_wpc_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
